[src/mcu_frame_receiver_event_queue_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the frame receiver and key event queue
// ---------------------------------------------------------------------------
`ifndef MCU_FRAME_RECEIVER_EVENT_QUEUE_UNIT_DEFINES_SVH
`define MCU_FRAME_RECEIVER_EVENT_QUEUE_UNIT_DEFINES_SVH

// Check on the rising clock, ignored while reset is high
`define MFREQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on the rising clock, also active across reset
`define MFREQ_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/mfreq_pkg.sv]
// ---------------------------------------------------------------------------
// mfreq_pkg
// Shared types, codes and constants of the frame receiver and event queue.
// ---------------------------------------------------------------------------
package mfreq_pkg;

   // Key event queue size and derived widths
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Frame layout
   localparam int FRAME_LEN = 5;

   localparam logic [7:0]  HDR_EVENT     = 8'h0a;
   localparam logic [7:0]  HDR_REPLY     = 8'ha0;
   localparam logic [23:0] CLR_LOW       = 24'h000050;
   localparam logic [23:0] CLR_HIGH      = 24'h000061;
   localparam logic [7:0]  REMOTE_BIT    = 8'h80;
   localparam logic [7:0]  TYPE_ALARM    = 8'd5;
   localparam logic [7:0]  TYPE_CHIP     = 8'd6;
   localparam logic [7:0]  TYPE_BOARD    = 8'd7;
   localparam logic [7:0]  TYPE_LOCAL_A  = 8'd1;
   localparam logic [7:0]  TYPE_REMOTE   = 8'd2;
   localparam logic [7:0]  TYPE_LOCAL_B  = 8'd3;
   localparam logic [15:0] CHIP_VER_RST  = 16'h1497;
   localparam logic [15:0] BOARD_VER_RST = 16'h0102;
   localparam logic [7:0]  REPLY_NONE    = 8'hff;

   // Input item kinds
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_ARM   = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   // Frame status codes on the result
   typedef enum logic [2:0] {
      ST_NONE    = 3'd0,
      ST_TAKEN   = 3'd1,
      ST_ACCEPT  = 3'd2,
      ST_SUM_BAD = 3'd3,
      ST_HDR_BAD = 3'd4
   } status_type;

   // Key source codes
   typedef enum logic [1:0] {
      SRC_LOCAL  = 2'd0,
      SRC_REMOTE = 2'd1,
      SRC_OTHER  = 2'd2
   } src_type;

   // Operations classified by the front end
   typedef enum logic [3:0] {
      OP_BYTE    = 4'd0,
      OP_HDR_BAD = 4'd1,
      OP_SUM_BAD = 4'd2,
      OP_ALARM   = 4'd3,
      OP_CHIP    = 4'd4,
      OP_BOARD   = 4'd5,
      OP_EVENT   = 4'd6,
      OP_REPLY   = 4'd7,
      OP_POP     = 4'd8,
      OP_ARM     = 4'd9,
      OP_CLEAR   = 4'd10
   } op_type;

   // One classified operation: data holds the word already assembled
   typedef struct packed {
      op_type      op;
      logic [23:0] data;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

   // One result item
   typedef struct packed {
      status_type  frame_status;
      logic        key_valid;
      logic [7:0]  key_code;
      logic [7:0]  key_press;
      src_type     key_source;
      logic [15:0] alarm_bits;
      logic [15:0] chip_version;
      logic [15:0] board_version;
      logic [7:0]  last_reply;
      logic [4:0]  queue_count;
   } rsp_type;

   // Advance a queue pointer with wrap at the queue depth
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

[src/mfreq_front.sv]
// ---------------------------------------------------------------------------
// mfreq_front
// Accepts items, assembles 5-byte frames, checks header and checksum and
// queues one classified operation per item in a two-entry buffer.
// ---------------------------------------------------------------------------
`include "mcu_frame_receiver_event_queue_unit_defines.svh"

module mfreq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_rx_byte,
   output mfreq_pkg::cmd_link_type cmd_link,
   input  logic                  cmd_take
);

   localparam logic [2:0] LAST_IDX = 3'(mfreq_pkg::FRAME_LEN - 1);

   logic [2:0]         byte_cnt_ff, byte_cnt_in;
   logic [7:0]         frame_ff [4];
   mfreq_pkg::cmd_type cq_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         cq_cnt_ff, cq_cnt_in;

   logic               accept;
   logic               store_byte;
   logic [7:0]         sum;
   mfreq_pkg::cmd_type cmd_new;

   assign full   = (cq_cnt_ff == 2'd2);
   assign accept = push && !full;

   // Classify the incoming item
   always_comb begin
      byte_cnt_in  = byte_cnt_ff;
      store_byte   = 1'b0;
      cmd_new.op   = mfreq_pkg::OP_BYTE;
      cmd_new.data = '0;
      sum          = frame_ff[0] + frame_ff[1] + frame_ff[2] + frame_ff[3];
      unique case (mfreq_pkg::kind_type'(req_kind))
         mfreq_pkg::KIND_BYTE: begin
            if (byte_cnt_ff == 3'd0 && req_rx_byte != mfreq_pkg::HDR_EVENT &&
                req_rx_byte != mfreq_pkg::HDR_REPLY) begin
               cmd_new.op = mfreq_pkg::OP_HDR_BAD;
            end else if (byte_cnt_ff != LAST_IDX) begin
               store_byte  = 1'b1;
               byte_cnt_in = byte_cnt_ff + 3'd1;
            end else begin
               byte_cnt_in = 3'd0;
               if (sum != req_rx_byte) begin
                  cmd_new.op = mfreq_pkg::OP_SUM_BAD;
               end else if (frame_ff[0] == mfreq_pkg::HDR_EVENT) begin
                  unique case (frame_ff[1])
                     mfreq_pkg::TYPE_ALARM: begin
                        cmd_new.op   = mfreq_pkg::OP_ALARM;
                        cmd_new.data = {8'd0, frame_ff[2], frame_ff[3]};
                     end
                     mfreq_pkg::TYPE_CHIP: begin
                        cmd_new.op   = mfreq_pkg::OP_CHIP;
                        cmd_new.data = {8'd0, frame_ff[3], frame_ff[2]};
                     end
                     mfreq_pkg::TYPE_BOARD: begin
                        cmd_new.op   = mfreq_pkg::OP_BOARD;
                        cmd_new.data = {8'd0, frame_ff[2], frame_ff[3]};
                     end
                     default: begin
                        cmd_new.op   = mfreq_pkg::OP_EVENT;
                        cmd_new.data = {frame_ff[3], frame_ff[2], frame_ff[1]};
                     end
                  endcase
               end else begin
                  cmd_new.op   = mfreq_pkg::OP_REPLY;
                  cmd_new.data = {16'd0, frame_ff[1]};
               end
            end
         end
         mfreq_pkg::KIND_POP:   cmd_new.op = mfreq_pkg::OP_POP;
         mfreq_pkg::KIND_ARM:   cmd_new.op = mfreq_pkg::OP_ARM;
         mfreq_pkg::KIND_CLEAR: cmd_new.op = mfreq_pkg::OP_CLEAR;
         default:               cmd_new.op = mfreq_pkg::OP_CLEAR;
      endcase
   end

   // Buffer pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ accept;
      rd_ptr_in = rd_ptr_ff ^ cmd_take;
      cq_cnt_in = cq_cnt_ff + {1'b0, accept} - {1'b0, cmd_take};
   end

   assign cmd_link.valid = (cq_cnt_ff != 2'd0);
   assign cmd_link.cmd   = cq_ff[rd_ptr_ff];

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= 3'd0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         cq_cnt_ff   <= 2'd0;
      end else begin
         if (accept) begin
            byte_cnt_ff <= byte_cnt_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cq_cnt_ff <= cq_cnt_in;
      end
   end

   // Frame bytes and buffered operations
   always_ff @(posedge clock) begin
      if (accept && store_byte) begin
         frame_ff[byte_cnt_ff[1:0]] <= req_rx_byte;
      end
      if (accept) begin
         cq_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   `MFREQ_ASSERT(a_byte_cnt_range, (byte_cnt_ff <= LAST_IDX), "frame byte counter out of range")
   `MFREQ_ASSERT(a_cq_no_overflow, (cq_cnt_ff <= 2'd2), "operation buffer overflow")

endmodule

[src/mfreq_back.sv]
// ---------------------------------------------------------------------------
// mfreq_back
// Carries out classified operations: status words, version registers, the
// reply latch and the key event queue; builds one result per operation.
// ---------------------------------------------------------------------------
`include "mcu_frame_receiver_event_queue_unit_defines.svh"

module mfreq_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mfreq_pkg::cmd_link_type cmd_link,
   output logic                    cmd_take,
   input  logic                    rsp_full,
   output logic                    rsp_push,
   output mfreq_pkg::rsp_type      rsp_data,
   input  logic                    csr_we,
   input  logic [15:0]             csr_wdata
);

   localparam int PW = mfreq_pkg::PTR_W;
   localparam int CW = mfreq_pkg::CNT_W;

   logic [15:0]   alarm_ff, alarm_in;
   logic          armed_ff, armed_in;
   logic [15:0]   chip_ff, chip_in;
   logic [15:0]   board_ff, board_in;
   logic [7:0]    reply_ff, reply_in;
   logic [23:0]   evq_ff [mfreq_pkg::QUEUE_DEPTH];
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   logic          fire;
   logic          ev_write;
   logic [PW-1:0] ev_idx;
   logic [23:0]   ev_head;
   logic [CW+4:0] cnt_wide;

   assign fire     = cmd_link.valid && !rsp_full;
   assign cmd_take = fire;
   assign rsp_push = fire;
   assign ev_head  = evq_ff[head_ff];

   // Execute one operation
   always_comb begin
      alarm_in = alarm_ff;
      armed_in = armed_ff;
      chip_in  = chip_ff;
      board_in = board_ff;
      reply_in = reply_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ev_write = 1'b0;
      ev_idx   = tail_ff;

      rsp_data.frame_status = mfreq_pkg::ST_NONE;
      rsp_data.key_valid    = 1'b0;
      rsp_data.key_code     = 8'd0;
      rsp_data.key_press    = 8'd0;
      rsp_data.key_source   = mfreq_pkg::SRC_LOCAL;

      if (fire) begin
         unique case (cmd_link.cmd.op)
            mfreq_pkg::OP_BYTE:    rsp_data.frame_status = mfreq_pkg::ST_TAKEN;
            mfreq_pkg::OP_HDR_BAD: rsp_data.frame_status = mfreq_pkg::ST_HDR_BAD;
            mfreq_pkg::OP_SUM_BAD: rsp_data.frame_status = mfreq_pkg::ST_SUM_BAD;
            mfreq_pkg::OP_ALARM: begin
               rsp_data.frame_status = mfreq_pkg::ST_ACCEPT;
               if (armed_ff) begin
                  alarm_in = cmd_link.cmd.data[15:0];
                  armed_in = 1'b0;
               end
            end
            mfreq_pkg::OP_CHIP: begin
               rsp_data.frame_status = mfreq_pkg::ST_ACCEPT;
               chip_in = cmd_link.cmd.data[15:0];
            end
            mfreq_pkg::OP_BOARD: begin
               rsp_data.frame_status = mfreq_pkg::ST_ACCEPT;
               board_in = cmd_link.cmd.data[15:0];
            end
            mfreq_pkg::OP_REPLY: begin
               rsp_data.frame_status = mfreq_pkg::ST_ACCEPT;
               reply_in = cmd_link.cmd.data[7:0];
            end
            mfreq_pkg::OP_EVENT: begin
               rsp_data.frame_status = mfreq_pkg::ST_ACCEPT;
               ev_write = 1'b1;
               if (cmd_link.cmd.data >= mfreq_pkg::CLR_LOW &&
                   cmd_link.cmd.data <= mfreq_pkg::CLR_HIGH) begin
                  // clearing key: queue restarts holding only this event
                  head_in  = '0;
                  ev_idx   = '0;
                  tail_in  = mfreq_pkg::ptr_inc('0);
                  count_in = CW'(1);
               end else if (count_ff == CW'(mfreq_pkg::QUEUE_DEPTH)) begin
                  // full: drop the oldest entry
                  head_in = mfreq_pkg::ptr_inc(head_ff);
                  tail_in = mfreq_pkg::ptr_inc(tail_ff);
               end else begin
                  tail_in  = mfreq_pkg::ptr_inc(tail_ff);
                  count_in = count_ff + CW'(1);
               end
            end
            mfreq_pkg::OP_POP: begin
               if (count_ff != '0) begin
                  head_in             = mfreq_pkg::ptr_inc(head_ff);
                  count_in            = count_ff - CW'(1);
                  rsp_data.key_valid  = 1'b1;
                  rsp_data.key_press  = ev_head[23:16];
                  rsp_data.key_code   = ev_head[15:8];
                  rsp_data.key_source = mfreq_pkg::SRC_OTHER;
                  if (ev_head[7:0] == mfreq_pkg::TYPE_LOCAL_A ||
                      ev_head[7:0] == mfreq_pkg::TYPE_LOCAL_B) begin
                     rsp_data.key_source = mfreq_pkg::SRC_LOCAL;
                  end else if (ev_head[7:0] == mfreq_pkg::TYPE_REMOTE) begin
                     rsp_data.key_source = mfreq_pkg::SRC_REMOTE;
                     rsp_data.key_code   = ev_head[15:8] | mfreq_pkg::REMOTE_BIT;
                  end
               end
            end
            mfreq_pkg::OP_ARM:   armed_in = 1'b1;
            mfreq_pkg::OP_CLEAR: reply_in = mfreq_pkg::REPLY_NONE;
            default: ;
         endcase
      end

      // register write loads the alarm word
      if (csr_we) begin
         alarm_in = csr_wdata;
      end

      cnt_wide = {5'd0, count_in};
      rsp_data.alarm_bits    = alarm_in;
      rsp_data.chip_version  = chip_in;
      rsp_data.board_version = board_in;
      rsp_data.last_reply    = reply_in;
      rsp_data.queue_count   = cnt_wide[4:0];
   end

   // Control and status state
   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff <= 16'd0;
         armed_ff <= 1'b0;
         chip_ff  <= mfreq_pkg::CHIP_VER_RST;
         board_ff <= mfreq_pkg::BOARD_VER_RST;
         reply_ff <= mfreq_pkg::REPLY_NONE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         alarm_ff <= alarm_in;
         armed_ff <= armed_in;
         chip_ff  <= chip_in;
         board_ff <= board_in;
         reply_ff <= reply_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Event storage
   always_ff @(posedge clock) begin
      if (ev_write) begin
         evq_ff[ev_idx] <= cmd_link.cmd.data;
      end
   end

   `MFREQ_ASSERT(a_evq_count_max, (count_ff <= CW'(mfreq_pkg::QUEUE_DEPTH)), "event count over depth")
   `MFREQ_ASSERT(a_empty_pop_hold, (fire && cmd_link.cmd.op == mfreq_pkg::OP_POP && count_ff == '0) |=> $stable(head_ff), "empty pop moved head")

endmodule

[src/mfreq_rsp_queue.sv]
// ---------------------------------------------------------------------------
// mfreq_rsp_queue
// Two-entry result buffer that decouples the executor from the result side.
// ---------------------------------------------------------------------------
`include "mcu_frame_receiver_event_queue_unit_defines.svh"

module mfreq_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_push,
   input  mfreq_pkg::rsp_type in_data,
   output logic               q_full,
   output logic               q_empty,
   input  logic               q_pop,
   output mfreq_pkg::rsp_type q_data
);

   mfreq_pkg::rsp_type buf_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_pop;

   assign q_full  = (count_ff == 2'd2);
   assign q_empty = (count_ff == 2'd0);
   assign do_pop  = q_pop && !q_empty;
   assign q_data  = buf_ff[rd_ptr_ff];

   // Pointer update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ in_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, in_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage
   always_ff @(posedge clock) begin
      if (in_push) begin
         buf_ff[wr_ptr_ff] <= in_data;
      end
   end

   `MFREQ_ASSERT_RST(a_rsp_empty_after_reset, reset |=> (count_ff == 2'd0), "result buffer not empty after reset")

endmodule

[src/mcu_frame_receiver_event_queue_unit.sv]
// ---------------------------------------------------------------------------
// mcu_frame_receiver_event_queue_unit
// Frame receiver and key event queue for a serial microcontroller link.
// ---------------------------------------------------------------------------
// Takes one item per clock while full is low (received byte, pop, arm
// alarm capture, clear reply) and returns exactly one result per item, in
// order. The item's transfer edge writes its classified operation into the
// front end's operation buffer. The executor then takes the operation,
// updates all status and queue state and writes the result into the result
// buffer, whose head drives the rsp_ ports. That executor sets the rate of
// one item per cycle while the result buffer has room. The two-entry buffers
// on either side of it let the input and result sides stall independently.
// A full result buffer holds the executor, and a full operation buffer then
// raises full. Write the alarm register only when no item is in flight.
`include "mcu_frame_receiver_event_queue_unit_defines.svh"

module mcu_frame_receiver_event_queue_unit (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_frame_status,
   output logic        rsp_key_valid,
   output logic [7:0]  rsp_key_code,
   output logic [7:0]  rsp_key_press,
   output logic [1:0]  rsp_key_source,
   output logic [15:0] rsp_alarm_bits,
   output logic [15:0] rsp_chip_version,
   output logic [15:0] rsp_board_version,
   output logic [7:0]  rsp_last_reply,
   output logic [4:0]  rsp_queue_count,
   // configuration
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   mfreq_pkg::cmd_link_type cmd_link;
   logic                    cmd_take;
   logic                    rq_full;
   logic                    rq_push;
   mfreq_pkg::rsp_type      rq_in;
   mfreq_pkg::rsp_type      rq_head;

   // Front end: framing and classification
   mfreq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .cmd_link    (cmd_link),
      .cmd_take    (cmd_take)
   );

   // Back end: state update and result build
   mfreq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_link  (cmd_link),
      .cmd_take  (cmd_take),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp_data  (rq_in),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Result buffer
   mfreq_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .in_push (rq_push),
      .in_data (rq_in),
      .q_full  (rq_full),
      .q_empty (empty),
      .q_pop   (pop),
      .q_data  (rq_head)
   );

   // Result fields
   assign rsp_frame_status  = rq_head.frame_status;
   assign rsp_key_valid     = rq_head.key_valid;
   assign rsp_key_code      = rq_head.key_code;
   assign rsp_key_press     = rq_head.key_press;
   assign rsp_key_source    = rq_head.key_source;
   assign rsp_alarm_bits    = rq_head.alarm_bits;
   assign rsp_chip_version  = rq_head.chip_version;
   assign rsp_board_version = rq_head.board_version;
   assign rsp_last_reply    = rq_head.last_reply;
   assign rsp_queue_count   = rq_head.queue_count;

endmodule
